[rtl/core/srr_pkg.sv]
// ----------------------------------------------------------------------------
// Selective-repeat receiver package
// Shared widths, types, state codes and control bundles for the receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

  // Sequence space and payload sizing.
  localparam int SEQ_BITS     = 3;
  localparam int SEQ_SPACE    = 1 << SEQ_BITS;
  localparam int PAYLOAD_BITS = 32;
  localparam int WIN_BITS     = 3;
  localparam int MAX_DELIVER  = 4;

  // Largest usable window: half the sequence space, capped by the delivery burst.
  localparam int WIN_LIMIT_INT = (SEQ_SPACE / 2 < MAX_DELIVER) ? SEQ_SPACE / 2 : MAX_DELIVER;

  // Stream beat layout: sequence number low, payload word above it, byte padded.
  localparam int BEAT_BITS  = SEQ_BITS + PAYLOAD_BITS;
  localparam int TDATA_BITS = ((BEAT_BITS + 7) / 8) * 8;
  localparam int PAD_BITS   = TDATA_BITS - BEAT_BITS;

  typedef logic [SEQ_BITS-1:0]     seq_t;
  typedef logic [PAYLOAD_BITS-1:0] word_t;
  typedef logic [WIN_BITS-1:0]     win_t;

  localparam win_t WIN_LIMIT   = win_t'(WIN_LIMIT_INT);
  localparam win_t WIN_RESET   = win_t'(4);

  // Result kinds carried on the output tuser bit.
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  // Operations of the shared sequence-number unit.
  typedef enum logic {
    ALU_DIST,
    ALU_STEP
  } alu_op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOOKUP,
    ST_DELIVER,
    ST_ACK
  } state_t;

  // Control from the sequencer to the packet store.
  typedef struct packed {
    logic wr_en;
    seq_t wr_addr;
    logic clr_en;
    logic rd_en;
    seq_t base_addr;
  } store_ctrl_t;

endpackage

[rtl/core/srr_alu.sv]
// ----------------------------------------------------------------------------
// Selective-repeat receiver sequence unit
// Shared modulo adder: window distance with in-window compare, or base step.
// ----------------------------------------------------------------------------
module srr_alu
  import srr_pkg::*;
(
  input  alu_op_t op,
  input  seq_t    a,
  input  seq_t    b,
  input  win_t    win,
  output seq_t    result,
  output logic    in_win
);

  // Modulo arithmetic wraps naturally at the sequence width.
  always_comb begin
    case (op)
      ALU_DIST: result = a - b;
      ALU_STEP: result = a + seq_t'(1);
      default:  result = a;
    endcase
  end

  // Distance from the window base compared against the window length.
  assign in_win = (int'(result) < int'(win));

endmodule

[rtl/core/srr_store.sv]
// ----------------------------------------------------------------------------
// Selective-repeat receiver packet store
// Payload memory with registered read, plus a received mark per sequence number.
// ----------------------------------------------------------------------------
module srr_store
  import srr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  store_ctrl_t ctrl,
  input  word_t       wr_data,
  output word_t       rd_data,
  output logic        base_mark
);

  word_t               mem [SEQ_SPACE];
  logic [SEQ_SPACE-1:0] mark;

  // Received marks: set when a packet is stored, cleared when it is delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= '0;
    end else begin
      if (ctrl.wr_en) begin
        mark[ctrl.wr_addr] <= 1'b1;
      end
      if (ctrl.clr_en) begin
        mark[ctrl.base_addr] <= 1'b0;
      end
    end
  end

  // Payload memory, read at the window base.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[ctrl.base_addr];
    end
  end

  assign base_mark = mark[ctrl.base_addr];

endmodule

[rtl/core/selective_repeat_receiver.sv]
// A corrupted packet is dropped with no beat; a good one outside the window goes from
// check to its ack beat, one inside goes check, lookup, then delivery and lookup for
// each of D deliveries, then ack. One packet is handled at a time; the shared modulo
// adder runs once per window check and once per delivered entry, and the store is
// read once per lookup. Reset (rst, synchronous, active high): window base 0, all
// received marks cleared, window size 4, sequencer idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Selective-repeat receiver
// Stores in-window packets, delivers in-order runs from the window base, then acks.
// ----------------------------------------------------------------------------
module selective_repeat_receiver
  import srr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration: window size.
  input  logic                  cfg_wr_en,
  input  logic [WIN_BITS-1:0]   cfg_wr_data,
  // Packet input.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_BITS-1:0] s_tdata,   // seq_num, payload_word, zero pad
  input  logic                  s_tuser,   // checksum_ok
  // Result output.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_BITS-1:0] m_tdata,   // deliver_data, ack_num, zero pad
  output logic                  m_tuser,   // kind
  output logic                  m_tlast    // last
);

  state_t      state;
  state_t      state_next;
  win_t        window_size;
  seq_t        base;
  seq_t        pkt_seq;
  word_t       pkt_data;
  win_t        win_eff;
  alu_op_t     alu_op;
  seq_t        alu_a;
  seq_t        alu_result;
  logic        alu_in_win;
  store_ctrl_t store_ctrl;
  word_t       rd_data;
  logic        base_mark;
  logic        in_accept;

  assign in_accept = s_tvalid && s_tready;

  // Effective window length.
  assign win_eff = (window_size > WIN_LIMIT) ? WIN_LIMIT : window_size;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WIN_RESET;
    end else if (cfg_wr_en) begin
      window_size <= cfg_wr_data;
    end
  end

  // Packet capture on an accepted beat.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pkt_seq  <= s_tdata[SEQ_BITS-1:0];
      pkt_data <= s_tdata[SEQ_BITS +: PAYLOAD_BITS];
    end
  end

  // Shared modulo unit: distance check, then base steps during delivery.
  assign alu_op = (state == ST_DELIVER) ? ALU_STEP : ALU_DIST;
  assign alu_a  = (state == ST_DELIVER) ? base : pkt_seq;

  srr_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (base),
    .win    (win_eff),
    .result (alu_result),
    .in_win (alu_in_win)
  );

  // Window base advances as each delivery beat leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (state == ST_DELIVER && m_tready) begin
      base <= alu_result;
    end
  end

  // Store control.
  always_comb begin
    store_ctrl.wr_en     = (state == ST_CHECK) && alu_in_win;
    store_ctrl.wr_addr   = pkt_seq;
    store_ctrl.clr_en    = (state == ST_DELIVER) && m_tready;
    store_ctrl.rd_en     = (state == ST_LOOKUP);
    store_ctrl.base_addr = base;
  end

  srr_store u_store (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (store_ctrl),
    .wr_data   (pkt_data),
    .rd_data   (rd_data),
    .base_mark (base_mark)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && s_tuser) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = alu_in_win ? ST_LOOKUP : ST_ACK;
      end
      ST_LOOKUP: begin
        state_next = base_mark ? ST_DELIVER : ST_ACK;
      end
      ST_DELIVER: begin
        if (m_tready) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_ACK: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output logic.
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    m_tuser  = KIND_DELIVER;
    m_tlast  = 1'b0;
    m_tdata  = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_DELIVER: begin
        m_tvalid = 1'b1;
        m_tdata  = {PAD_BITS'(0), seq_t'(0), rd_data};
      end
      ST_ACK: begin
        m_tvalid = 1'b1;
        m_tuser  = KIND_ACK;
        m_tlast  = 1'b1;
        m_tdata  = {PAD_BITS'(0), pkt_seq, word_t'(0)};
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // A delivery is only ever shown for a marked entry at the window base.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DELIVER) |-> base_mark)
    else $error("delivery beat without a received mark at the base");

  // Each accepted delivery beat moves the base by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DELIVER && m_tready) |=> (base == $past(base) + seq_t'(1)))
    else $error("window base did not advance by one after a delivery");

  // A corrupted packet produces no beat and leaves the block ready.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && !s_tuser) |=> (s_tready && !m_tvalid))
    else $error("corrupted packet produced activity");

  // The ack beat ends the packet and the block returns to accepting input.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser == KIND_ACK) |=> s_tready)
    else $error("block not ready after the ack beat");

  // The base never moves while the block waits for a packet.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && $past(state) == ST_IDLE) |-> $stable(base))
    else $error("window base moved while idle");

endmodule

[verif/srr_monitor.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Selective-repeat receiver monitor
// Watches the configuration port and both streams, keeps its own copy of the
// receive window, predicts every delivery and ack beat and compares them.
// ----------------------------------------------------------------------------
module srr_monitor
  import srr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [WIN_BITS-1:0]   cfg_wr_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [TDATA_BITS-1:0] s_tdata,   // seq_num, payload_word, zero pad
  input  logic                  s_tuser,   // checksum_ok
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [TDATA_BITS-1:0] m_tdata,   // deliver_data, ack_num, zero pad
  input  logic                  m_tuser,   // kind
  input  logic                  m_tlast,   // last
  output int                    fail_count,
  output int                    results_due
);

  // One output beat as the receiver should produce it.
  typedef struct packed {
    logic  kind;
    word_t data;
    seq_t  ack;
    logic  last;
  } rx_result_t;

  rx_result_t due_q[$];
  rx_result_t got;
  rx_result_t want;

  // Shadow copy of the receiver state.
  win_t                 win_size;
  seq_t                 win_base;
  logic [SEQ_SPACE-1:0] marked;
  word_t                buffer [SEQ_SPACE];

  // Usable window: capped at half the sequence space and the delivery burst.
  function automatic int usable_window();
    int n;
    n = int'(win_size);
    if (n > WIN_LIMIT_INT) n = WIN_LIMIT_INT;
    return n;
  endfunction

  // Store an intact packet if it falls in the window, release the in-order
  // run from the base, then queue the ack.
  function automatic void receive_packet(seq_t seq, word_t word);
    seq_t       offset;
    rx_result_t r;
    int         n;
    offset = seq - win_base;
    if (int'(offset) < usable_window()) begin
      marked[seq] = 1'b1;
      buffer[seq] = word;
      n = 0;
      while (n < MAX_DELIVER && marked[win_base]) begin
        r.kind = KIND_DELIVER;
        r.data = buffer[win_base];
        r.ack  = '0;
        r.last = 1'b0;
        due_q.push_back(r);
        marked[win_base] = 1'b0;
        win_base = win_base + 1'b1;
        n++;
      end
    end
    r.kind = KIND_ACK;
    r.data = '0;
    r.ack  = seq;
    r.last = 1'b1;
    due_q.push_back(r);
  endfunction

  // Sample all channels at the clock edge; inputs settle after it.
  always @(posedge clk) begin
    if (rst) begin
      win_size   = WIN_RESET;
      win_base   = '0;
      marked     = '0;
      fail_count = 0;
      due_q.delete();
    end else begin
      if (cfg_wr_en) win_size = cfg_wr_data;
      if (s_tvalid && s_tready && s_tuser) begin
        receive_packet(s_tdata[SEQ_BITS-1:0], s_tdata[SEQ_BITS +: PAYLOAD_BITS]);
      end
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.data = m_tdata[PAYLOAD_BITS-1:0];
        got.ack  = m_tdata[PAYLOAD_BITS +: SEQ_BITS];
        got.last = m_tlast;
        if (due_q.size() == 0) begin
          $display("%0t: unexpected beat kind=%0d data=%h ack=%0d last=%0d",
                   $time, got.kind, got.data, got.ack, got.last);
          fail_count++;
        end else begin
          want = due_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected kind=%0d data=%h ack=%0d last=%0d",
                     $time, want.kind, want.data, want.ack, want.last);
            $display("%0t:           actual kind=%0d data=%h ack=%0d last=%0d",
                     $time, got.kind, got.data, got.ack, got.last);
            fail_count++;
          end
        end
      end
    end
    results_due = due_q.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Selective-repeat receiver testbench
// Drives directed and sender-like random packet traffic under several idle
// and stall patterns and window sizes; the monitor checks every result beat.
// ----------------------------------------------------------------------------
module tb_top;
  import srr_pkg::*;

  localparam int STALL_LIMIT = 1000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [WIN_BITS-1:0]   cfg_wr_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [TDATA_BITS-1:0] s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_BITS-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  int   fail_count;
  int   results_due;
  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  int   cur_window     = 4;
  int   items_sent     = 0;
  int   stall_cycles   = 0;
  seq_t snd_base;
  int   win_plan [8]   = '{4, 1, 3, 7, 2, 0, 6, 5};

  selective_repeat_receiver dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  srr_monitor u_monitor (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // 10 ns clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random backpressure on the result stream.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: too long without any beat on either side ends the run.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Payload words with the all-zero and all-one extremes mixed in.
  function automatic word_t pick_word();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Present one packet beat and wait until it is taken.
  task automatic send_packet(logic ok, seq_t seq, word_t word);
    logic [TDATA_BITS-1:0] beat;
    beat = '0;
    beat[SEQ_BITS-1:0] = seq;
    beat[SEQ_BITS +: PAYLOAD_BITS] = word;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= ok;
    s_tdata  <= beat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Change the window size once the receiver has drained.
  task automatic set_window(int w);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= win_t'(w);
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    cur_window = w;
  endtask

  // Sender-like traffic: each burst covers the window in shuffled order with
  // corrupted copies, retransmissions and stale duplicates sprinkled in.
  task automatic run_segment(int n_items);
    int   target;
    int   burst;
    int   j;
    int   k;
    seq_t tmp;
    seq_t order [MAX_DELIVER];
    target = items_sent + n_items;
    while (items_sent < target) begin
      burst = (cur_window == 0) ? 1 :
              (cur_window > WIN_LIMIT_INT) ? WIN_LIMIT_INT : cur_window;
      for (k = 0; k < burst; k++) order[k] = snd_base + seq_t'(k);
      for (k = burst - 1; k > 0; k--) begin
        j = $urandom_range(k);
        tmp = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      for (k = 0; k < burst; k++) begin
        case ($urandom_range(9))
          0: send_packet(1'b0, seq_t'($urandom), word_t'($urandom));
          1: send_packet(1'b1, seq_t'(snd_base - 1 - $urandom_range(3)), pick_word());
          default: ;
        endcase
        if ($urandom_range(7) == 0) send_packet(1'b0, order[k], word_t'($urandom));
        send_packet(1'b1, order[k], pick_word());
        if ($urandom_range(9) == 0) send_packet(1'b1, order[k], pick_word());
      end
      if (cur_window != 0) snd_base = snd_base + seq_t'(burst);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset window of four, base zero.
    send_packet(1'b0, 3'd0, 32'hFFFF_FFFF);   // corrupted: nothing comes out
    send_packet(1'b1, 3'd1, 32'hFFFF_FFFF);   // stored ahead of the base
    send_packet(1'b1, 3'd1, 32'h5A5A_5A5A);   // already marked: payload replaced
    send_packet(1'b1, 3'd3, 32'hA5A5_A5A5);
    send_packet(1'b1, 3'd4, 32'h0000_0001);   // just past the window edge
    send_packet(1'b1, 3'd2, 32'h0000_0000);
    send_packet(1'b1, 3'd0, 32'h1234_5678);   // releases a full run of four
    send_packet(1'b1, 3'd0, 32'hDEAD_BEEF);   // duplicate already delivered
    send_packet(1'b1, 3'd7, 32'hFFFF_FFFF);
    send_packet(1'b0, 3'd4, 32'h8000_0000);
    send_packet(1'b1, 3'd4, 32'h0000_0000);   // base moves to five

    // Window size zero: packets are only acknowledged.
    set_window(0);
    send_packet(1'b1, 3'd5, 32'h7FFF_FFFF);
    send_packet(1'b0, 3'd5, 32'h0000_0000);

    // Oversized window is limited to four; the run wraps past seven.
    set_window(7);
    send_packet(1'b1, 3'd6, 32'hCAFE_F00D);
    send_packet(1'b1, 3'd0, 32'h0F0F_0F0F);
    send_packet(1'b1, 3'd1, 32'hF0F0_F0F0);
    send_packet(1'b1, 3'd5, 32'hFFFF_FFFF);   // base moves to one

    // Window of one.
    set_window(1);
    send_packet(1'b1, 3'd2, 32'h1111_1111);
    send_packet(1'b1, 3'd1, 32'h2222_2222);
    send_packet(1'b1, 3'd2, 32'h3333_3333);
    snd_base = 3'd3;

    // Random traffic: no idling, idle sender, stalling receiver, then both.
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = (p == 1) ? 68 : (p == 3) ? 30 : 0;
      sink_stall_pct = (p == 2) ? 68 : (p == 3) ? 30 : 0;
      for (int h = 0; h < 2; h++) begin
        set_window(win_plan[2 * p + h]);
        run_segment(56);
      end
    end

    // Drain the result stream.
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
